// ----- rtl/core/ldcm_pkg.sv -----
package ldcm_pkg;

    // Input transaction: output pixel position
    typedef struct packed {
        logic [12:0] pixel_col;
        logic [12:0] pixel_row;
    } pix_t;

    // Output transaction: source sample position in Q24.16
    typedef struct packed {
        logic signed [39:0] source_x;
        logic signed [39:0] source_y;
        logic               range_flag;
    } src_t;

    // Saturating add result
    typedef struct packed {
        logic               sat;
        logic signed [63:0] val;
    } sat_val_t;

    // Register indexes
    localparam logic [2:0] REG_FOCAL_X    = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y    = 3'd1;
    localparam logic [2:0] REG_CENTER_X   = 3'd2;
    localparam logic [2:0] REG_CENTER_Y   = 3'd3;
    localparam logic [2:0] REG_RADIAL_NUM = 3'd4;
    localparam logic [2:0] REG_RADIAL_DEN = 3'd5;
    localparam logic [2:0] REG_TANGENTIAL = 3'd6;

    // Q.32 limits and constants
    localparam logic signed [63:0] LIM       = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] LIM_W     = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE_Q32   = 64'sh0000_0001_0000_0000;
    localparam logic        [31:0] FOCAL_MIN = 32'h0001_0000;
    localparam logic signed [64:0] OUT_MAX   = 65'sh0_0000_007F_FFFF_FFFF;
    localparam logic signed [64:0] OUT_MIN   = -65'sh0_0000_0080_0000_0000;

    // Fixed-point multiplier pipeline depth
    localparam int FMUL_LAT = 4;

    // a + b clipped to +-LIM, with a saturation mark
    function automatic sat_val_t sat_add(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
        logic signed [64:0] s;
        sat_val_t           r;
        s = {a[63], a} + {b[63], b};
        if (s > LIM_W) begin
            r.sat = 1'b1;
            r.val = LIM;
        end
        else if (s < -LIM_W) begin
            r.sat = 1'b1;
            r.val = -LIM;
        end
        else begin
            r.sat = 1'b0;
            r.val = s[63:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/ldcm_delay.sv -----
module ldcm_delay
    import ldcm_pkg::*;
#(
    parameter int W = 64,
    parameter int N = 4
)(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [N];

    // Shift line, advancing with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[N-1];

endmodule

// ----- rtl/core/ldcm_fmul.sv -----
module ldcm_fmul
    import ldcm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p,
    output logic               sat
);

    // trunc(a*b / 2^32), magnitude clipped to LIM; inputs within +-LIM

    logic        [62:0] ua_reg, ub_reg;
    logic               neg1_reg, neg2_reg, neg3_reg;
    logic        [61:0] hh_reg, hh3_reg;
    logic        [62:0] hl_reg, lh_reg;
    logic        [63:0] ll_reg;
    logic        [64:0] mid_reg;
    logic signed [63:0] p_reg;
    logic               sat_reg;

    logic signed [63:0] na, nb;
    logic        [94:0] tot;
    logic        [62:0] smag;
    logic               ovf;

    assign na = -a;
    assign nb = -b;

    // Final sum and clip
    always_comb
    begin
        tot  = {1'b0, hh3_reg, 32'b0} + {30'b0, mid_reg};
        ovf  = tot > {32'b0, LIM[62:0]};
        smag = ovf ? LIM[62:0] : tot[62:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitudes
            ua_reg   <= a[63] ? na[62:0] : a[62:0];
            ub_reg   <= b[63] ? nb[62:0] : b[62:0];
            neg1_reg <= a[63] ^ b[63];
            // partial products
            hh_reg   <= ua_reg[62:32] * ub_reg[62:32];
            hl_reg   <= ua_reg[62:32] * ub_reg[31:0];
            lh_reg   <= ua_reg[31:0] * ub_reg[62:32];
            ll_reg   <= ua_reg[31:0] * ub_reg[31:0];
            neg2_reg <= neg1_reg;
            // middle terms
            mid_reg  <= {2'b0, hl_reg} + {2'b0, lh_reg} + {33'b0, ll_reg[63:32]};
            hh3_reg  <= hh_reg;
            neg3_reg <= neg2_reg;
            // sign
            p_reg    <= neg3_reg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
            sat_reg  <= ovf;
        end
    end

    assign p   = p_reg;
    assign sat = sat_reg;

endmodule

// ----- rtl/core/ldcm_div.sv -----
module ldcm_div
    import ldcm_pkg::*;
#(
    parameter int DW     = 32,
    parameter int QUO_W  = 49,
    parameter int SIDE_W = 1
)(
    input  logic              clk,
    input  logic              en,
    input  logic [DW-1:0]     rem_i,
    input  logic [DW-1:0]     div_i,
    input  logic [QUO_W-1:0]  feed_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic [QUO_W-1:0]  quo_o,
    output logic [SIDE_W-1:0] side_o
);

    // Restoring division, one quotient bit per stage.
    // The remainder stays below the divisor; feed supplies dividend bits MSB first.

    logic [DW-1:0]     rem_reg  [QUO_W];
    logic [DW-1:0]     div_reg  [QUO_W];
    logic [QUO_W-1:0]  feed_reg [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [DW-1:0]     rem_s, div_s;
        logic [QUO_W-1:0]  feed_s, quo_s;
        logic [SIDE_W-1:0] side_s;
        logic [DW:0]       trial, diff;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rem_s  = rem_i;
            assign div_s  = div_i;
            assign feed_s = feed_i;
            assign quo_s  = '0;
            assign side_s = side_i;
        end
        else
        begin : g_next
            assign rem_s  = rem_reg[k-1];
            assign div_s  = div_reg[k-1];
            assign feed_s = feed_reg[k-1];
            assign quo_s  = quo_reg[k-1];
            assign side_s = side_reg[k-1];
        end

        assign trial = {rem_s, feed_s[QUO_W-1]};
        assign diff  = trial - {1'b0, div_s};
        assign ge    = trial >= {1'b0, div_s};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                div_reg[k]  <= div_s;
                feed_reg[k] <= {feed_s[QUO_W-2:0], 1'b0};
                quo_reg[k]  <= {quo_s[QUO_W-2:0], ge};
                side_reg[k] <= side_s;
            end
        end
    end

    assign quo_o  = quo_reg[QUO_W-1];
    assign side_o = side_reg[QUO_W-1];

endmodule

// ----- rtl/core/lens_distortion_coordinate_map.sv -----
// An input transaction reaches its result transaction through the bit-per-stage dividers
// and the 4-stage multipliers.
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n, async, active low) empties the pipeline and loads the
// registers with focal 1.0, center 0 and all coefficients 0.
module lens_distortion_coordinate_map
    import ldcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    output logic        pix_ready,
    input  pix_t        pix,
    output logic        src_valid,
    input  logic        src_ready,
    output src_t        src,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int NRM_Q_W = 49;
    localparam int RAD_Q_W = 62;
    localparam int T_U     = 1;
    localparam int T_XN    = T_U + NRM_Q_W + 1;
    localparam int T_SQ    = T_XN + FMUL_LAT;
    localparam int T_R2    = T_SQ + 1;
    localparam int T_AXY   = T_R2 + 1;
    localparam int T_R4    = T_R2 + FMUL_LAT;
    localparam int T_R6    = T_R4 + FMUL_LAT;
    localparam int T_KT    = T_R6 + FMUL_LAT;
    localparam int T_S1    = T_KT + 1;
    localparam int T_S2    = T_S1 + 1;
    localparam int T_S3    = T_S2 + 1;
    localparam int T_TG    = T_AXY + FMUL_LAT;
    localparam int T_TD    = T_TG + 1;
    localparam int T_DM    = T_S3 + 1;
    localparam int T_DS    = T_DM + 1;
    localparam int T_DQ    = T_DS + RAD_Q_W;
    localparam int T_RAD   = T_DQ + 1;
    localparam int T_XM    = T_RAD + FMUL_LAT;
    localparam int T_D1    = T_XM + 1;
    localparam int T_D2    = T_D1 + 1;
    localparam int T_F     = T_D2 + FMUL_LAT;
    localparam int T_OUT   = T_F + 1;

    // ---------------- configuration registers ----------------
    logic [31:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [62:0] rnum_reg, rden_reg;
    logic [63:0] tang_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= FOCAL_MIN;
            focal_y_reg  <= FOCAL_MIN;
            center_x_reg <= '0;
            center_y_reg <= '0;
            rnum_reg     <= '0;
            rden_reg     <= '0;
            tang_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FOCAL_X:    focal_x_reg  <= cfg_data[31:0];
                REG_FOCAL_Y:    focal_y_reg  <= cfg_data[31:0];
                REG_CENTER_X:   center_x_reg <= cfg_data[31:0];
                REG_CENTER_Y:   center_y_reg <= cfg_data[31:0];
                REG_RADIAL_NUM: rnum_reg     <= cfg_data[62:0];
                REG_RADIAL_DEN: rden_reg     <= cfg_data[62:0];
                REG_TANGENTIAL: tang_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Effective focal lengths and widened coefficients
    logic        [31:0] fx, fy;
    logic signed [63:0] k1, k2, k3, k4, k5, k6, p1, p2;

    assign fx = (focal_x_reg < FOCAL_MIN) ? FOCAL_MIN : focal_x_reg;
    assign fy = (focal_y_reg < FOCAL_MIN) ? FOCAL_MIN : focal_y_reg;
    assign k1 = {{29{rnum_reg[20]}}, rnum_reg[20:0], 14'b0};
    assign k2 = {{29{rnum_reg[41]}}, rnum_reg[41:21], 14'b0};
    assign k3 = {{29{rnum_reg[62]}}, rnum_reg[62:42], 14'b0};
    assign k4 = {{29{rden_reg[20]}}, rden_reg[20:0], 14'b0};
    assign k5 = {{29{rden_reg[41]}}, rden_reg[41:21], 14'b0};
    assign k6 = {{29{rden_reg[62]}}, rden_reg[62:42], 14'b0};
    assign p1 = {{28{tang_reg[31]}}, tang_reg[31:0], 4'b0};
    assign p2 = {{28{tang_reg[63]}}, tang_reg[63:32], 4'b0};

    // ---------------- pipeline control ----------------
    logic             en;
    logic [T_OUT:1]   valid_reg, flag_reg, flag_next, sat_at;

    assign en        = !valid_reg[T_OUT] || src_ready;
    assign pix_ready = en;
    assign src_valid = valid_reg[T_OUT];
    assign flag_next = {flag_reg[T_OUT-1:1], 1'b0} | sat_at;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            flag_reg  <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[T_OUT-1:1], pix_valid};
            flag_reg  <= flag_next;
        end
    end

    // ---------------- offset from principal point ----------------
    logic signed [33:0] dx, dy;
    logic        [32:0] ux_reg, uy_reg;
    logic               nx_reg, ny_reg;
    logic signed [33:0] ndx, ndy;

    assign dx  = $signed({5'b0, pix.pixel_col, 16'b0}) - $signed({2'b0, center_x_reg});
    assign dy  = $signed({5'b0, pix.pixel_row, 16'b0}) - $signed({2'b0, center_y_reg});
    assign ndx = -dx;
    assign ndy = -dy;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= dx[33] ? ndx[32:0] : dx[32:0];
            uy_reg <= dy[33] ? ndy[32:0] : dy[32:0];
            nx_reg <= dx[33];
            ny_reg <= dy[33];
        end
    end

    // ---------------- normalize: u * 2^32 / focal ----------------
    logic [NRM_Q_W-1:0] qx, qy;
    logic               sgx, sgy;

    ldcm_div #(.DW(32), .QUO_W(NRM_Q_W), .SIDE_W(1)) u_div_nx (
        .clk(clk), .en(en),
        .rem_i({16'b0, ux_reg[32:17]}), .div_i(fx),
        .feed_i({ux_reg[16:0], 32'b0}), .side_i(nx_reg),
        .quo_o(qx), .side_o(sgx)
    );

    ldcm_div #(.DW(32), .QUO_W(NRM_Q_W), .SIDE_W(1)) u_div_ny (
        .clk(clk), .en(en),
        .rem_i({16'b0, uy_reg[32:17]}), .div_i(fy),
        .feed_i({uy_reg[16:0], 32'b0}), .side_i(ny_reg),
        .quo_o(qy), .side_o(sgy)
    );

    logic signed [63:0] xn_reg, yn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xn_reg <= sgx ? -$signed({15'b0, qx}) : $signed({15'b0, qx});
            yn_reg <= sgy ? -$signed({15'b0, qy}) : $signed({15'b0, qy});
        end
    end

    // ---------------- squares and cross term ----------------
    logic signed [63:0] xx, yy, xy;
    logic               xx_sat, yy_sat, xy_sat;

    ldcm_fmul u_m_xx (.clk(clk), .en(en), .a(xn_reg), .b(xn_reg), .p(xx), .sat(xx_sat));
    ldcm_fmul u_m_yy (.clk(clk), .en(en), .a(yn_reg), .b(yn_reg), .p(yy), .sat(yy_sat));
    ldcm_fmul u_m_xy (.clk(clk), .en(en), .a(xn_reg), .b(yn_reg), .p(xy), .sat(xy_sat));

    sat_val_t           r2_s, ax1_s, ay1_s, ax_s, ay_s;
    logic signed [63:0] r2_reg, ax1_reg, ay1_reg, ax_reg, ay_reg, xy1_reg, xy2_reg;

    assign r2_s  = sat_add(xx, yy);
    assign ax1_s = sat_add(xx, xx);
    assign ay1_s = sat_add(yy, yy);
    assign ax_s  = sat_add(r2_reg, ax1_reg);
    assign ay_s  = sat_add(r2_reg, ay1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg  <= r2_s.val;
            ax1_reg <= ax1_s.val;
            ay1_reg <= ay1_s.val;
            xy1_reg <= xy;
            ax_reg  <= ax_s.val;
            ay_reg  <= ay_s.val;
            xy2_reg <= xy1_reg;
        end
    end

    // ---------------- radial powers ----------------
    logic signed [63:0] r4, r6, r2_a, r2_b, r4_b;
    logic               r4_sat, r6_sat;

    ldcm_fmul u_m_r4 (.clk(clk), .en(en), .a(r2_reg), .b(r2_reg), .p(r4), .sat(r4_sat));

    ldcm_delay #(.W(64), .N(FMUL_LAT)) u_d_r2a (.clk(clk), .en(en), .d(r2_reg), .q(r2_a));

    ldcm_fmul u_m_r6 (.clk(clk), .en(en), .a(r4), .b(r2_a), .p(r6), .sat(r6_sat));

    ldcm_delay #(.W(64), .N(FMUL_LAT)) u_d_r2b (.clk(clk), .en(en), .d(r2_a), .q(r2_b));
    ldcm_delay #(.W(64), .N(FMUL_LAT)) u_d_r4b (.clk(clk), .en(en), .d(r4), .q(r4_b));

    // ---------------- polynomial terms ----------------
    logic signed [63:0] tn1, tn2, tn3, td1, td2, td3;
    logic               tn1_sat, tn2_sat, tn3_sat, td1_sat, td2_sat, td3_sat;

    ldcm_fmul u_m_n1 (.clk(clk), .en(en), .a(k1), .b(r2_b), .p(tn1), .sat(tn1_sat));
    ldcm_fmul u_m_n2 (.clk(clk), .en(en), .a(k2), .b(r4_b), .p(tn2), .sat(tn2_sat));
    ldcm_fmul u_m_n3 (.clk(clk), .en(en), .a(k3), .b(r6), .p(tn3), .sat(tn3_sat));
    ldcm_fmul u_m_d1 (.clk(clk), .en(en), .a(k4), .b(r2_b), .p(td1), .sat(td1_sat));
    ldcm_fmul u_m_d2 (.clk(clk), .en(en), .a(k5), .b(r4_b), .p(td2), .sat(td2_sat));
    ldcm_fmul u_m_d3 (.clk(clk), .en(en), .a(k6), .b(r6), .p(td3), .sat(td3_sat));

    // ---------------- tangential terms ----------------
    logic signed [63:0] pxy1, pax, pay, pxy2;
    logic               pxy1_sat, pax_sat, pay_sat, pxy2_sat;

    ldcm_fmul u_m_pxy1 (.clk(clk), .en(en), .a(p1), .b(xy2_reg), .p(pxy1), .sat(pxy1_sat));
    ldcm_fmul u_m_pax  (.clk(clk), .en(en), .a(p2), .b(ax_reg), .p(pax), .sat(pax_sat));
    ldcm_fmul u_m_pay  (.clk(clk), .en(en), .a(p1), .b(ay_reg), .p(pay), .sat(pay_sat));
    ldcm_fmul u_m_pxy2 (.clk(clk), .en(en), .a(p2), .b(xy2_reg), .p(pxy2), .sat(pxy2_sat));

    sat_val_t           tx_s, ty_s;
    logic signed [63:0] tx_reg, ty_reg, pax_reg, pay_reg;

    assign tx_s = sat_add(pxy1, pxy1);
    assign ty_s = sat_add(pxy2, pxy2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg  <= tx_s.val;
            ty_reg  <= ty_s.val;
            pax_reg <= pax;
            pay_reg <= pay;
        end
    end

    logic signed [63:0] tx_d, pay_d, pax_d, ty_d;

    ldcm_delay #(.W(64), .N(T_XM - T_TD)) u_d_tx  (.clk(clk), .en(en), .d(tx_reg), .q(tx_d));
    ldcm_delay #(.W(64), .N(T_XM - T_TD)) u_d_pay (.clk(clk), .en(en), .d(pay_reg), .q(pay_d));
    ldcm_delay #(.W(64), .N(T_D1 - T_TD)) u_d_pax (.clk(clk), .en(en), .d(pax_reg), .q(pax_d));
    ldcm_delay #(.W(64), .N(T_D1 - T_TD)) u_d_ty  (.clk(clk), .en(en), .d(ty_reg), .q(ty_d));

    // ---------------- numerator and denominator sums ----------------
    sat_val_t           n1_s, n2_s, n3_s, d1_s, d2_s, d3_s;
    logic signed [63:0] n1_reg, n2_reg, n3_reg, d1_reg, d2_reg, d3_reg;
    logic signed [63:0] tn2_reg, tn3a_reg, tn3b_reg, td2_reg, td3a_reg, td3b_reg;

    assign n1_s = sat_add(ONE_Q32, tn1);
    assign d1_s = sat_add(ONE_Q32, td1);
    assign n2_s = sat_add(n1_reg, tn2_reg);
    assign d2_s = sat_add(d1_reg, td2_reg);
    assign n3_s = sat_add(n2_reg, tn3b_reg);
    assign d3_s = sat_add(d2_reg, td3b_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= n1_s.val;
            d1_reg   <= d1_s.val;
            tn2_reg  <= tn2;
            td2_reg  <= td2;
            tn3a_reg <= tn3;
            td3a_reg <= td3;
            n2_reg   <= n2_s.val;
            d2_reg   <= d2_s.val;
            tn3b_reg <= tn3a_reg;
            td3b_reg <= td3a_reg;
            n3_reg   <= n3_s.val;
            d3_reg   <= d3_s.val;
        end
    end

    // ---------------- radial quotient ----------------
    logic signed [63:0] nn, nd;
    logic        [62:0] un_reg, ud_reg, ud2_reg, r0_reg;
    logic        [61:0] feed_reg;
    logic               zero_reg, dneg_reg, zero2_reg, dneg2_reg, ovf_reg;

    assign nn = -n3_reg;
    assign nd = -d3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg  <= (d3_reg == '0);
            un_reg    <= n3_reg[63] ? nn[62:0] : n3_reg[62:0];
            ud_reg    <= d3_reg[63] ? nd[62:0] : d3_reg[62:0];
            dneg_reg  <= n3_reg[63] ^ d3_reg[63];
            // integer part of 2^30 or more saturates
            ovf_reg   <= {30'b0, un_reg} >= {ud_reg, 30'b0};
            r0_reg    <= {30'b0, un_reg[62:30]};
            feed_reg  <= {un_reg[29:0], 32'b0};
            ud2_reg   <= ud_reg;
            zero2_reg <= zero_reg;
            dneg2_reg <= dneg_reg;
        end
    end

    logic [RAD_Q_W-1:0] qr;
    logic [2:0]         rside;
    logic               zero_q, ovf_q, neg_q;

    ldcm_div #(.DW(63), .QUO_W(RAD_Q_W), .SIDE_W(3)) u_div_rad (
        .clk(clk), .en(en),
        .rem_i(r0_reg), .div_i(ud2_reg),
        .feed_i(feed_reg), .side_i({zero2_reg, ovf_reg, dneg2_reg}),
        .quo_o(qr), .side_o(rside)
    );

    assign {zero_q, ovf_q, neg_q} = rside;

    logic signed [63:0] rad_reg, qs;
    logic               zr_reg, ovr_reg;

    assign qs = ovf_q ? LIM : $signed({2'b0, qr});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= neg_q ? -qs : qs;
            zr_reg  <= zero_q;
            ovr_reg <= ovf_q & ~zero_q;
        end
    end

    // ---------------- distorted normalized position ----------------
    logic signed [63:0] xn_d, yn_d, xm, ym;
    logic               xm_sat, ym_sat;

    ldcm_delay #(.W(64), .N(T_RAD - T_XN)) u_d_xn (.clk(clk), .en(en), .d(xn_reg), .q(xn_d));
    ldcm_delay #(.W(64), .N(T_RAD - T_XN)) u_d_yn (.clk(clk), .en(en), .d(yn_reg), .q(yn_d));

    ldcm_fmul u_m_xm (.clk(clk), .en(en), .a(xn_d), .b(rad_reg), .p(xm), .sat(xm_sat));
    ldcm_fmul u_m_ym (.clk(clk), .en(en), .a(yn_d), .b(rad_reg), .p(ym), .sat(ym_sat));

    sat_val_t           xd1_s, yd1_s, xd2_s, yd2_s;
    logic signed [63:0] xd1_reg, yd1_reg, xd2_reg, yd2_reg;

    assign xd1_s = sat_add(xm, tx_d);
    assign yd1_s = sat_add(ym, pay_d);
    assign xd2_s = sat_add(xd1_reg, pax_d);
    assign yd2_s = sat_add(yd1_reg, ty_d);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd1_reg <= xd1_s.val;
            yd1_reg <= yd1_s.val;
            xd2_reg <= xd2_s.val;
            yd2_reg <= yd2_s.val;
        end
    end

    // ---------------- back to pixels ----------------
    logic signed [63:0] fxm, fym;
    logic               fxm_sat, fym_sat, zero_f;

    ldcm_fmul u_m_fx (.clk(clk), .en(en), .a(xd2_reg), .b($signed({32'b0, fx})),
                      .p(fxm), .sat(fxm_sat));
    ldcm_fmul u_m_fy (.clk(clk), .en(en), .a(yd2_reg), .b($signed({32'b0, fy})),
                      .p(fym), .sat(fym_sat));

    ldcm_delay #(.W(1), .N(T_F - T_RAD)) u_d_zero (.clk(clk), .en(en), .d(zr_reg),
                                                   .q(zero_f));

    logic signed [64:0] sx, sy;
    logic signed [39:0] sx_c, sy_c, sx_reg, sy_reg;
    logic               sx_hit, sy_hit;

    // Add center, clamp to Q24.16
    always_comb
    begin
        sx = {fxm[63], fxm} + $signed({33'b0, center_x_reg});
        sy = {fym[63], fym} + $signed({33'b0, center_y_reg});
        sx_hit = 1'b1;
        sy_hit = 1'b1;
        if (sx > OUT_MAX)
            sx_c = OUT_MAX[39:0];
        else if (sx < OUT_MIN)
            sx_c = OUT_MIN[39:0];
        else
        begin
            sx_c   = sx[39:0];
            sx_hit = 1'b0;
        end
        if (sy > OUT_MAX)
            sy_c = OUT_MAX[39:0];
        else if (sy < OUT_MIN)
            sy_c = OUT_MIN[39:0];
        else
        begin
            sy_c   = sy[39:0];
            sy_hit = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= zero_f ? '0 : sx_c;
            sy_reg <= zero_f ? '0 : sy_c;
        end
    end

    // ---------------- saturation marks per stage ----------------
    always_comb
    begin
        sat_at = '0;
        sat_at[T_R2]   = sat_at[T_R2] | xx_sat | yy_sat | xy_sat
                         | r2_s.sat | ax1_s.sat | ay1_s.sat;
        sat_at[T_AXY]  = sat_at[T_AXY] | ax_s.sat | ay_s.sat;
        sat_at[T_R4+1] = sat_at[T_R4+1] | r4_sat;
        sat_at[T_R6+1] = sat_at[T_R6+1] | r6_sat;
        sat_at[T_TD]   = sat_at[T_TD] | pxy1_sat | pax_sat | pay_sat | pxy2_sat
                         | tx_s.sat | ty_s.sat;
        sat_at[T_S1]   = sat_at[T_S1] | tn1_sat | tn2_sat | tn3_sat
                         | td1_sat | td2_sat | td3_sat | n1_s.sat | d1_s.sat;
        sat_at[T_S2]   = sat_at[T_S2] | n2_s.sat | d2_s.sat;
        sat_at[T_S3]   = sat_at[T_S3] | n3_s.sat | d3_s.sat;
        sat_at[T_RAD]  = sat_at[T_RAD] | (ovf_q & ~zero_q);
        sat_at[T_RAD+1] = sat_at[T_RAD+1] | ovr_reg;
        sat_at[T_D1]   = sat_at[T_D1] | xm_sat | ym_sat | xd1_s.sat | yd1_s.sat;
        sat_at[T_D2]   = sat_at[T_D2] | xd2_s.sat | yd2_s.sat;
        sat_at[T_OUT]  = sat_at[T_OUT] | fxm_sat | fym_sat | sx_hit | sy_hit | zero_f;
    end

    assign src.source_x   = sx_reg;
    assign src.source_y   = sy_reg;
    assign src.range_flag = flag_reg[T_OUT];

endmodule
